// ===== hw/rtl/tss_pkg.sv =====
// Shared types and constants for the fixed-step tick scheduler.
// Depends on nothing; every other file in hw/rtl imports it.
`default_nettype none

package tss_pkg;

	localparam int unsigned TIME_W    = 32;  // microsecond quantities
	localparam int unsigned SUM_W     = 33;  // accumulator plus frame time
	localparam int unsigned TOT_W     = 64;  // running totals
	localparam int unsigned TICK_W    = 8;   // tick cap and ticks per frame
	localparam int unsigned ALPHA_W   = 16;  // interpolation fraction field
	localparam int unsigned ITER_W    = 6;   // divider iteration count
	localparam int unsigned MUL_CNT_W = 4;   // multiplier iteration count
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [TIME_W-1:0] STEP_DEFAULT      = 32'd16667;
	localparam logic [TIME_W-1:0] FRAME_MAX_DEFAULT = 32'd100000;
	localparam logic [TICK_W-1:0] TICK_CAP_DEFAULT  = 8'd8;

	localparam logic [CFG_IDX_W-1:0] CFG_FIXED_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TICKS  = 2'd2;

	localparam logic FUNC_ADVANCE = 1'b0;
	localparam logic FUNC_CLEAR   = 1'b1;

	typedef struct packed {
		logic              func;
		logic [TIME_W-1:0] raw_delta;
	} in_t;

	typedef struct packed {
		logic [TICK_W-1:0]  ticks_to_run;
		logic [SUM_W-1:0]   dropped_ticks;
		logic [TIME_W-1:0]  frame_delta;
		logic [TOT_W-1:0]   dropped_time;
		logic [ALPHA_W-1:0] alpha;
		logic [TOT_W-1:0]   frame_total;
		logic [TOT_W-1:0]   tick_total;
		logic [TOT_W-1:0]   dropped_tick_total;
		logic [TOT_W-1:0]   sim_time_total;
		logic [TOT_W-1:0]   real_time_total;
		logic [TOT_W-1:0]   dropped_time_total;
		logic [TIME_W-1:0]  accum_left;
	} out_t;

	typedef struct packed {
		logic              start;
		logic [ITER_W-1:0] iters;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tss_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tss_pkg; shared by the step split and the fraction.
`default_nettype none

module tss_div import tss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  div_req_t          req,
	input  logic [SUM_W-1:0]  dividend,
	input  logic [TIME_W-1:0] rem_init,
	input  logic [TIME_W-1:0] divisor,
	output unit_sts_t         sts,
	output logic [SUM_W-1:0]  quo,
	output logic [TIME_W-1:0] rem
);

	logic [SUM_W-1:0]  dvd_q;
	logic [SUM_W-1:0]  quo_q;
	logic [TIME_W-1:0] rem_q;
	logic [ITER_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [TIME_W+1:0] diff;
	logic              ge;
	logic [TIME_W-1:0] rem_nxt;

	// Partial remainder stays below the divisor, so 32 bits carry it.
	always_comb begin
		diff    = {1'b0, rem_q, dvd_q[SUM_W-1]} - {2'b00, divisor};
		ge      = ~diff[TIME_W+1];
		rem_nxt = ge ? diff[TIME_W-1:0] : {rem_q[TIME_W-2:0], dvd_q[SUM_W-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - ITER_W'(1);
				if (cnt_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= dividend;
			rem_q <= rem_init;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
			rem_q <= rem_nxt;
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quo      = quo_q;
	assign rem      = rem_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tss_mul.sv =====
// Bit-serial shift-add multiplier, tick count by step length, MSB first.
// Depends on tss_pkg; the product never exceeds the 33-bit frame sum.
`default_nettype none

module tss_mul import tss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TICK_W-1:0] mplier,
	input  logic [TIME_W-1:0] mcand,
	output unit_sts_t         sts,
	output logic [SUM_W-1:0]  prod
);

	logic [SUM_W-1:0]     acc_q;
	logic [TICK_W-1:0]    mpl_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [SUM_W-1:0]     acc_nxt;

	// Partial products are the product shifted down, so they fit too.
	assign acc_nxt = {acc_q[SUM_W-2:0], 1'b0}
		+ (mpl_q[TICK_W-1] ? {1'b0, mcand} : SUM_W'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MUL_CNT_W'(TICK_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - MUL_CNT_W'(1);
				if (cnt_q == MUL_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mpl_q <= mplier;
		end else if (busy_q) begin
			acc_q <= acc_nxt;
			mpl_q <= {mpl_q[TICK_W-2:0], 1'b0};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign prod     = acc_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fixed_step_tick_scheduler.sv =====
// Fixed-step tick scheduler. An advance transaction runs the 33-step serial
// split of the frame sum into whole steps and a remainder, and then the
// ALPHA_BITS-step serial division of that remainder into the fraction.
// A clear transaction goes from ST_IDLE straight to ST_FIN, where its result is loaded.
// One item in flight: the block is ready for the next in the cycle after the result is loaded.
// Reset: asynchronous, active low; totals zero, registers at defaults.
`default_nettype none

module fixed_step_tick_scheduler import tss_pkg::*; #(
	parameter int unsigned ALPHA_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_t                 out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_QSTART,
		ST_QWAIT,
		ST_CAP,
		ST_FSTART,
		ST_FWAIT,
		ST_DT,
		ST_FIN
	} state_t;

	function automatic logic [TOT_W-1:0] sat_add(
		input logic [TOT_W-1:0] a,
		input logic [TOT_W-1:0] b
	);
		logic [TOT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
	endfunction

	// Configuration registers and their effective values (zero selects default)
	logic [TIME_W-1:0] fixed_step_q;
	logic [TIME_W-1:0] max_frame_q;
	logic [TICK_W-1:0] max_ticks_q;
	logic [TIME_W-1:0] step_eff;
	logic [TIME_W-1:0] fmax_eff;
	logic [TICK_W-1:0] cap_eff;

	state_t            state_q;
	logic              clr_q;
	logic [TIME_W-1:0] raw_q;
	logic [TIME_W-1:0] fd_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  whole_q;
	logic [SUM_W-1:0]  wstep_q;
	logic [TICK_W-1:0] run_q;
	logic [SUM_W-1:0]  drop_q;
	logic [SUM_W-1:0]  dtime_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic [TIME_W-1:0] accum_q;

	logic [TOT_W-1:0]  frames_q;
	logic [TOT_W-1:0]  ticks_q;
	logic [TOT_W-1:0]  lost_q;
	logic [TOT_W-1:0]  sim_q;
	logic [TOT_W-1:0]  real_q;
	logic [TOT_W-1:0]  tlost_q;

	out_t              out_q;
	logic              out_valid_q;

	// Serial units; only the divider is shared
	div_req_t          div_req;
	unit_sts_t         div_sts;
	logic [SUM_W-1:0]  div_dvd;
	logic [TIME_W-1:0] div_rinit;
	logic [SUM_W-1:0]  div_quo;
	logic [TIME_W-1:0] div_rem;
	unit_sts_t         mul_sts;
	logic [SUM_W-1:0]  mul_prod;

	// Combinational helpers
	logic              out_free;
	logic [TICK_W-1:0] run_d;
	logic [TOT_W-1:0]  frames_n;
	logic [TOT_W-1:0]  ticks_n;
	logic [TOT_W-1:0]  lost_n;
	logic [TOT_W-1:0]  sim_n;
	logic [TOT_W-1:0]  real_n;
	logic [TOT_W-1:0]  tlost_n;

	assign step_eff = (fixed_step_q == '0) ? STEP_DEFAULT : fixed_step_q;
	assign fmax_eff = (max_frame_q == '0) ? FRAME_MAX_DEFAULT : max_frame_q;
	assign cap_eff  = (max_ticks_q == '0) ? TICK_CAP_DEFAULT : max_ticks_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	// Register writes; an index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_step_q <= STEP_DEFAULT;
			max_frame_q  <= FRAME_MAX_DEFAULT;
			max_ticks_q  <= TICK_CAP_DEFAULT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FIXED_STEP: fixed_step_q <= cfg_data;
				CFG_MAX_FRAME:  max_frame_q  <= cfg_data;
				CFG_MAX_TICKS:  max_ticks_q  <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// The divider first splits the frame sum into whole steps and a
	// remainder, then works out the remainder as a fraction of a step.
	always_comb begin
		div_req.start = (state_q == ST_QSTART) || (state_q == ST_FSTART);
		if (state_q == ST_QSTART) begin
			div_req.iters = ITER_W'(SUM_W);
			div_dvd       = sum_q;
			div_rinit     = '0;
		end else begin
			div_req.iters = ITER_W'(ALPHA_BITS);
			div_dvd       = '0;
			div_rinit     = accum_q;
		end
	end

	tss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dvd),
		.rem_init (div_rinit),
		.divisor  (step_eff),
		.sts      (div_sts),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// Executed step time: ticks run times step, alongside the fraction
	tss_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_FSTART),
		.mplier (run_q),
		.mcand  (step_eff),
		.sts    (mul_sts),
		.prod   (mul_prod)
	);

	// Clamp the whole steps to the tick cap
	assign run_d = (whole_q < SUM_W'(cap_eff)) ? whole_q[TICK_W-1:0] : cap_eff;

	// Running totals, each saturating at all ones
	assign frames_n = sat_add(frames_q, TOT_W'(1));
	assign real_n   = sat_add(real_q, TOT_W'(raw_q));
	assign ticks_n  = sat_add(ticks_q, TOT_W'(run_q));
	assign lost_n   = sat_add(lost_q, TOT_W'(drop_q));
	assign sim_n    = sat_add(sim_q, TOT_W'(mul_prod));
	assign tlost_n  = sat_add(tlost_q, TOT_W'(dtime_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			clr_q       <= 1'b0;
			raw_q       <= '0;
			fd_q        <= '0;
			sum_q       <= '0;
			whole_q     <= '0;
			wstep_q     <= '0;
			run_q       <= '0;
			drop_q      <= '0;
			dtime_q     <= '0;
			alpha_q     <= '0;
			accum_q     <= '0;
			frames_q    <= '0;
			ticks_q     <= '0;
			lost_q      <= '0;
			sim_q       <= '0;
			real_q      <= '0;
			tlost_q     <= '0;
		end else begin
			// Retire the held result once the sink takes it; in ST_FIN the
			// next result takes its place instead
			if (out_valid_q && out_ready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						clr_q <= in_data.func;
						raw_q <= in_data.raw_delta;
						fd_q  <= (in_data.raw_delta < fmax_eff) ? in_data.raw_delta
							: fmax_eff;
						state_q <= (in_data.func == FUNC_CLEAR) ? ST_FIN : ST_SUM;
					end
				end
				ST_SUM: begin
					sum_q   <= {1'b0, accum_q} + {1'b0, fd_q};
					state_q <= ST_QSTART;
				end
				ST_QSTART: begin
					state_q <= ST_QWAIT;
				end
				ST_QWAIT: begin
					if (div_sts.done) begin
						whole_q <= div_quo;
						accum_q <= div_rem;
						state_q <= ST_CAP;
					end
				end
				ST_CAP: begin
					run_q   <= run_d;
					drop_q  <= whole_q - SUM_W'(run_d);
					wstep_q <= sum_q - {1'b0, accum_q};
					state_q <= ST_FSTART;
				end
				ST_FSTART: begin
					state_q <= ST_FWAIT;
				end
				ST_FWAIT: begin
					if (div_sts.done) begin
						alpha_q <= div_quo[ALPHA_W-1:0];
						state_q <= ST_DT;
					end
				end
				ST_DT: begin
					// Dropped time: whole-step time less the time run
					if (!mul_sts.busy) begin
						dtime_q <= wstep_q - mul_prod;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (clr_q) begin
							accum_q  <= '0;
							frames_q <= '0;
							ticks_q  <= '0;
							lost_q   <= '0;
							sim_q    <= '0;
							real_q   <= '0;
							tlost_q  <= '0;
							out_q    <= '0;
						end else begin
							frames_q <= frames_n;
							ticks_q  <= ticks_n;
							lost_q   <= lost_n;
							sim_q    <= sim_n;
							real_q   <= real_n;
							tlost_q  <= tlost_n;
							out_q.ticks_to_run       <= run_q;
							out_q.dropped_ticks      <= drop_q;
							out_q.frame_delta        <= fd_q;
							out_q.dropped_time       <= TOT_W'(dtime_q);
							out_q.alpha              <= alpha_q;
							out_q.frame_total        <= frames_n;
							out_q.tick_total         <= ticks_n;
							out_q.dropped_tick_total <= lost_n;
							out_q.sim_time_total     <= sim_n;
							out_q.real_time_total    <= real_n;
							out_q.dropped_time_total <= tlost_n;
							out_q.accum_left         <= accum_q;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tss_checker.sv =====
// Port-level checks for the fixed-step tick scheduler, bound to the top.
// Depends on tss_pkg and fixed_step_tick_scheduler.
`default_nettype none

module tss_checker import tss_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// One transaction in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// Dropped steps and dropped time agree on being zero
	a_drop_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.dropped_ticks == '0) == (out_data.dropped_time == '0)))
		else $error("dropped ticks and dropped time disagree");

	// Steps are dropped only when ticks_to_run is nonzero
	a_drop_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.dropped_ticks != '0) |-> (out_data.ticks_to_run != '0))
		else $error("ticks dropped with none run");

	// No frame since the last clear means no tick, sim-time or real-time totals either
	a_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.frame_total == '0) |->
			(out_data.tick_total == '0) && (out_data.sim_time_total == '0)
			&& (out_data.real_time_total == '0))
		else $error("totals without frames");

endmodule

bind fixed_step_tick_scheduler tss_checker u_tss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

// ===== bench/fixed_step_tick_scheduler_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for fixed_step_tick_scheduler: frame and configuration traffic
// against an in-bench accumulator ledger. Depends on tss_pkg and the scheduler RTL.

module fixed_step_tick_scheduler_test;
	import tss_pkg::*;

	localparam int unsigned ALPHA_BITS     = 16;
	localparam int unsigned SETTLE_CYCLES  = 80;    // wait after the last drain before the verdict
	localparam int unsigned WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
	localparam int unsigned PHASES         = 8;
	localparam int unsigned PHASE_FRAMES   = 160;

	// Index that decodes to no register; the block must ignore it.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	// Accumulator ledger: mirrors the scheduler state and configuration, works out
	// the report each frame transaction must produce and matches reports in order.
	class tick_ledger;
		logic [TIME_W-1:0] step_reg;
		logic [TIME_W-1:0] frame_reg;
		logic [TICK_W-1:0] cap_reg;
		logic [TIME_W-1:0] accum;
		logic [TOT_W-1:0]  frames;
		logic [TOT_W-1:0]  ticks_run;
		logic [TOT_W-1:0]  ticks_dropped;
		logic [TOT_W-1:0]  sim_us;
		logic [TOT_W-1:0]  real_us;
		logic [TOT_W-1:0]  lost_us;
		out_t              frame_reports[$];
		int unsigned       mismatches;
		int unsigned       reports_seen;

		function new();
			step_reg      = STEP_DEFAULT;
			frame_reg     = FRAME_MAX_DEFAULT;
			cap_reg       = TICK_CAP_DEFAULT;
			accum         = '0;
			frames        = '0;
			ticks_run     = '0;
			ticks_dropped = '0;
			sim_us        = '0;
			real_us       = '0;
			lost_us       = '0;
			mismatches    = 0;
			reports_seen  = 0;
		endfunction

		function logic [TOT_W-1:0] sat_add(logic [TOT_W-1:0] a, logic [TOT_W-1:0] b);
			logic [TOT_W:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[TOT_W] ? '1 : s[TOT_W-1:0];
		endfunction

		function int unsigned outstanding();
			return frame_reports.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] value);
			case (idx)
				CFG_FIXED_STEP: step_reg = value;
				CFG_MAX_FRAME:  frame_reg = value;
				CFG_MAX_TICKS:  cap_reg = value[TICK_W-1:0];
				default: ;
			endcase
		endfunction

		function void account_frame(in_t item);
			logic [63:0] step_us;
			logic [63:0] fmax_us;
			logic [63:0] cap_n;
			logic [63:0] fd;
			logic [63:0] sum;
			logic [63:0] whole;
			logic [63:0] run;
			logic [63:0] drop;
			logic [63:0] num;
			logic [63:0] frac;
			out_t        rep;

			rep     = '0;
			step_us = 64'((step_reg != 0) ? step_reg : STEP_DEFAULT);
			fmax_us = 64'((frame_reg != 0) ? frame_reg : FRAME_MAX_DEFAULT);
			cap_n   = 64'((cap_reg != 0) ? cap_reg : TICK_CAP_DEFAULT);

			if (item.func == FUNC_CLEAR) begin
				accum         = '0;
				frames        = '0;
				ticks_run     = '0;
				ticks_dropped = '0;
				sim_us        = '0;
				real_us       = '0;
				lost_us       = '0;
			end else begin
				fd      = (64'(item.raw_delta) < fmax_us) ? 64'(item.raw_delta) : fmax_us;
				frames  = sat_add(frames, 64'd1);
				real_us = sat_add(real_us, 64'(item.raw_delta));
				sum     = 64'(accum) + fd;
				whole   = sum / step_us;
				if (whole != 0) begin
					run   = (whole < cap_n) ? whole : cap_n;
					drop  = whole - run;
					accum = TIME_W'(sum % step_us);
					ticks_run     = sat_add(ticks_run, run);
					ticks_dropped = sat_add(ticks_dropped, drop);
					sim_us        = sat_add(sim_us, run * step_us);
					lost_us       = sat_add(lost_us, drop * step_us);
					rep.ticks_to_run  = run[TICK_W-1:0];
					rep.dropped_ticks = drop[SUM_W-1:0];
					rep.dropped_time  = drop * step_us;
				end else begin
					accum = sum[TIME_W-1:0];
				end
				num  = {32'd0, accum};
				num  = num << ALPHA_BITS;
				frac = num / step_us;
				rep.frame_delta = fd[TIME_W-1:0];
				rep.alpha       = frac[ALPHA_W-1:0];
			end

			rep.frame_total        = frames;
			rep.tick_total         = ticks_run;
			rep.dropped_tick_total = ticks_dropped;
			rep.sim_time_total     = sim_us;
			rep.real_time_total    = real_us;
			rep.dropped_time_total = lost_us;
			rep.accum_left         = accum;
			frame_reports.push_back(rep);
		endfunction

		task flag(string msg);
			mismatches++;
			$display("[%0t] report %0d: %s", $time, reports_seen, msg);
		endtask

		task cmp_field(string name, logic [63:0] got, logic [63:0] want);
			if (got !== want)
				flag($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
		endtask

		task match_report(out_t got);
			out_t want;
			reports_seen++;
			if (frame_reports.size() == 0) begin
				flag("report with no frame transaction outstanding");
				return;
			end
			want = frame_reports.pop_front();
			cmp_field("ticks_to_run", 64'(got.ticks_to_run), 64'(want.ticks_to_run));
			cmp_field("dropped_ticks", 64'(got.dropped_ticks), 64'(want.dropped_ticks));
			cmp_field("frame_delta", 64'(got.frame_delta), 64'(want.frame_delta));
			cmp_field("dropped_time", got.dropped_time, want.dropped_time);
			cmp_field("alpha", 64'(got.alpha), 64'(want.alpha));
			cmp_field("frame_total", got.frame_total, want.frame_total);
			cmp_field("tick_total", got.tick_total, want.tick_total);
			cmp_field("dropped_tick_total", got.dropped_tick_total, want.dropped_tick_total);
			cmp_field("sim_time_total", got.sim_time_total, want.sim_time_total);
			cmp_field("real_time_total", got.real_time_total, want.real_time_total);
			cmp_field("dropped_time_total", got.dropped_time_total, want.dropped_time_total);
			cmp_field("accum_left", 64'(got.accum_left), 64'(want.accum_left));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_t                  in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_t                 out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TIME_W-1:0]    cfg_data;

	logic                 no_idle;
	int unsigned          quiet_cycles;
	tick_ledger           ledger = new();

	fixed_step_tick_scheduler #(
		.ALPHA_BITS(ALPHA_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Report side: drop ready at random, about 11 times in a hundred, unless the
	// current phase runs without idling.
	always @(posedge clk) begin
		out_ready <= no_idle || ($urandom_range(0, 99) >= 11);
	end

	// Observe every handshake at the clock edge. Frame transactions go into the
	// ledger, reports are matched against it, register writes update its copy.
	// The watchdog counts edges with no transaction on any channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				ledger.account_frame(in_data);
			if (out_valid && out_ready)
				ledger.match_report(out_data);
			if (cfg_valid && cfg_ready)
				ledger.write_reg(cfg_index, cfg_data);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("fixed_step_tick_scheduler test failed");
				$finish;
			end
		end
	end

	// Present one frame transaction. Idle beforehand at random (valid low), then
	// hold valid and payload until the block takes it. Valid is left high on
	// return so that a back-to-back transaction needs no second assignment.
	task automatic push_frame(input in_t item);
		while (!no_idle && $urandom_range(0, 99) < 11) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic advance(input logic [TIME_W-1:0] us);
		push_frame('{func: FUNC_ADVANCE, raw_delta: us});
	endtask

	task automatic clear_totals();
		push_frame('{func: FUNC_CLEAR, raw_delta: $urandom});
	endtask

	// Hold off the frame channel until every outstanding report has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (ledger.outstanding() != 0);
	endtask

	// One register write; cfg_valid stays high on return for the same reason
	// as in push_frame, so the caller lowers it after the last write.
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Rewrite all three registers with the block idle; optionally poke the
	// unused index, which must change nothing.
	task automatic configure(input logic [TIME_W-1:0] step_us, input logic [TIME_W-1:0] frame_us,
			input logic [TIME_W-1:0] ticks_word, input bit poke_unused);
		drain_results();
		set_reg(CFG_FIXED_STEP, step_us);
		set_reg(CFG_MAX_FRAME, frame_us);
		if (poke_unused)
			set_reg(CFG_UNUSED, $urandom);
		set_reg(CFG_MAX_TICKS, ticks_word);
		cfg_valid <= 1'b0;
	endtask

	// Frame time biased towards the current step and clamp, with full-range
	// values and both ends mixed in.
	function automatic logic [TIME_W-1:0] pick_delta();
		logic [63:0]       span;
		logic [TIME_W-1:0] fmax_us;
		span    = 64'd3 * 64'((ledger.step_reg != 0) ? ledger.step_reg : STEP_DEFAULT);
		fmax_us = (ledger.frame_reg != 0) ? ledger.frame_reg : FRAME_MAX_DEFAULT;
		if (span > 64'hFFFF_FFFF)
			span = 64'hFFFF_FFFF;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return fmax_us;
			3: return fmax_us - 32'd1;
			4, 5: return $urandom;
			default: return $urandom_range(0, span[31:0]);
		endcase
	endfunction

	initial begin
		logic [TIME_W-1:0] step_us;
		logic [TIME_W-1:0] frame_us;
		logic [TIME_W-1:0] ticks_word;
		in_t               item;

		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		in_data      <= '0;
		out_ready    <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		no_idle      <= 1'b0;
		quiet_cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: below one step, exactly one step, clamped frames.
		advance(32'd0);
		advance(32'd16666);
		advance(32'd1);
		advance(32'd100000);
		advance(32'hFFFF_FFFF);
		clear_totals();
		advance(32'h8000_0000);

		// Unit step, no clamp worth the name, cap of one: billions of dropped
		// steps. Junk above the cap field must be discarded.
		configure(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FF01, 1'b1);
		advance(32'hFFFF_FFFF);
		advance(32'h5555_5555);
		advance(32'hAAAA_AAAA);
		clear_totals();

		// Longest step with a one-microsecond clamp, then lift the clamp so that
		// the frame sum carries into bit 32.
		configure(32'hFFFF_FFFF, 32'd1, 32'd255, 1'b0);
		advance(32'hFFFF_FFFF);
		drain_results();
		set_reg(CFG_MAX_FRAME, 32'hFFFF_FFFF);
		cfg_valid <= 1'b0;
		advance(32'hFFFF_FFFF);
		advance(32'hFFFF_FFFE);

		// Remainder one below a half-range step: alpha at its top value.
		configure(32'h8000_0000, 32'hFFFF_FFFF, 32'd255, 1'b0);
		advance(32'hFFFF_FFFF);

		// Zero writes select every default.
		configure(32'd0, 32'd0, 32'd0, 1'b0);
		advance(32'd50000);

		// Short step with default clamp and cap: frames over the cap drop steps.
		configure(32'd10, 32'd0, 32'd0, 1'b0);
		advance(32'd95);
		advance(32'd100000);
		clear_totals();
		advance(32'd7);

		// Random phases, each under a fresh setting; one phase runs flat out.
		for (int ph = 0; ph < PHASES; ph++) begin
			case ($urandom_range(0, 4))
				0: begin
					step_us    = '0;
					frame_us   = '0;
					ticks_word = $urandom & 32'hFFFF_FF00;
				end
				1: begin
					step_us    = $urandom_range(1, 100);
					frame_us   = $urandom;
					ticks_word = $urandom;
				end
				2: begin
					step_us    = $urandom;
					frame_us   = $urandom;
					ticks_word = $urandom;
				end
				3: begin
					step_us    = $urandom_range(1000, 40000);
					frame_us   = $urandom_range(0, 200000);
					ticks_word = $urandom_range(0, 16);
				end
				default: begin
					step_us    = $urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF;
					frame_us   = $urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF;
					ticks_word = {24'($urandom_range(0, 32'hFF_FFFF)),
						($urandom_range(0, 1) ? 8'd1 : 8'd255)};
				end
			endcase
			configure(step_us, frame_us, ticks_word, 1'($urandom_range(0, 1)));
			no_idle <= (ph == 3);

			for (int n = 0; n < PHASE_FRAMES; n++) begin
				// now and then hold the sender back until the block has caught up
				if ($urandom_range(0, 39) == 0)
					drain_results();
				item.func      = ($urandom_range(0, 24) == 0) ? FUNC_CLEAR : FUNC_ADVANCE;
				item.raw_delta = pick_delta();
				push_frame(item);
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (ledger.mismatches == 0 && ledger.outstanding() == 0)
			$display("fixed_step_tick_scheduler test passed");
		else
			$display("fixed_step_tick_scheduler test failed");
		$finish;
	end

endmodule
